@@ rtl/cubic_quadrature_integrator_defines.svh @@
// assertion macros for the cubic quadrature integrator checker
`ifndef CUBIC_QUADRATURE_INTEGRATOR_DEFINES_SVH
`define CUBIC_QUADRATURE_INTEGRATOR_DEFINES_SVH

// same-cycle implication
`define CQI_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CQI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/cqi_pkg.sv @@
// shared types and constants of the cubic quadrature integrator
`timescale 1ns / 1ps
package cqi_pkg;
	localparam int BND_W = 16;
	localparam int CNT_W = 13;
	localparam int AREA_W = 40;
	localparam int DVD_W = 48;
	localparam int MUL_W = 33;
	localparam int DEF_MAX_INTERVALS = 4096;
	localparam logic OP_TRAP = 1'b0;
	localparam logic OP_SIMP = 1'b1;

	typedef struct packed {
		logic start;
		logic [DVD_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} div_req_t;
endpackage

@@ rtl/cqi_div.sv @@
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module cqi_div (
	input logic clk,
	input logic arst_n,
	input cqi_pkg::div_req_t req,
	output logic done,
	output logic [cqi_pkg::DVD_W-1:0] quotient
);
	import cqi_pkg::*;
	localparam int R_W = CNT_W + 1;
	localparam int C_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] dvd_q;
	logic [R_W-1:0] rem_q;
	logic [CNT_W-1:0] dvs_q;
	logic [C_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [R_W-1:0] shifted;
	logic take;

	assign shifted = {rem_q[R_W-2:0], dvd_q[DVD_W-1]};
	assign take = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && !req.start && (cnt_q == C_W'(DVD_W - 1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == C_W'(DVD_W - 1)) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= take ? (shifted - {1'b0, dvs_q}) : shifted;
			dvd_q <= {dvd_q[DVD_W-2:0], take};
		end
	end

	assign done = done_q;
	assign quotient = dvd_q;
endmodule

@@ rtl/cqi_mul.sv @@
// shared registered signed multiplier
`timescale 1ns / 1ps
module cqi_mul (
	input logic clk,
	input logic signed [cqi_pkg::MUL_W-1:0] a,
	input logic signed [cqi_pkg::MUL_W-1:0] b,
	output logic signed [2*cqi_pkg::MUL_W-1:0] p
);
	import cqi_pkg::*;
	logic signed [2*MUL_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign p = p_q;
endmodule

@@ rtl/cubic_quadrature_integrator.sv @@
// top level: sequencer of the trapezoid and simpson integrator of x^3+10x+1
// For one request (n saturated to MAX_INTERVALS), the step size takes a pass through
// the bit-serial divider and its registered done flag, each of the n+1 sample points
// needs two passes through the shared multiplier and one accumulate step, the final
// product takes the states ST_MP_LO, ST_MP_HI and ST_MP_SUM, the scale by 2 is a shift
// and the scale by 3 is a divide by three done 12 bits at a time. in_ready is high
// only while the sequencer is idle; a finished result waits in the output register
// while the next request is taken. A zero interval count returns error with area 0
// and the block is ready again once the result leaves ST_DONE for the output register.
`timescale 1ns / 1ps
module cubic_quadrature_integrator #(
	parameter int MAX_INTERVALS = cqi_pkg::DEF_MAX_INTERVALS
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic op,
	input logic signed [cqi_pkg::BND_W-1:0] lower_bound,
	input logic signed [cqi_pkg::BND_W-1:0] upper_bound,
	input logic [cqi_pkg::CNT_W-1:0] interval_count,
	output logic out_valid,
	input logic out_ready,
	output logic signed [cqi_pkg::AREA_W-1:0] area,
	output logic error
);
	import cqi_pkg::*;
	localparam int X_W = 30;
	localparam int S_W = 48;
	localparam int F_W = 34;
	localparam int D3_W = 12;
	localparam logic [DVD_W-1:0] POS_LIM = 48'h7F_FFFF_FFFF;
	localparam logic [DVD_W-1:0] NEG_LIM = 48'h80_0000_0000;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DIV_H, ST_SQ, ST_CB, ST_AC, ST_MP_LO, ST_MP_HI, ST_MP_SUM,
		ST_DIV_A, ST_SAT, ST_DONE
	} state_t;

	state_t state_q;
	logic op_q, neg_h_q, neg_a_q, err_q, out_valid_q, out_err_q;
	logic signed [BND_W-1:0] lo_q, hi_q;
	logic [CNT_W-1:0] n_q, idx_q;
	logic signed [X_W-1:0] h_q, x_q, x_cur_q;
	logic signed [S_W-1:0] sum_q;
	logic [2*MUL_W-1:0] p_lo_q;
	logic signed [AREA_W-1:0] res_q, area_q;
	logic [DVD_W-1:0] q3_q;
	logic [1:0] r3_q;
	logic [1:0] cnt3_q;

	div_req_t dreq;
	logic div_done;
	logic [DVD_W-1:0] quo;
	logic signed [MUL_W-1:0] ma, mb;
	logic signed [2*MUL_W-1:0] mp;

	logic in_acc;
	logic out_load;
	logic [CNT_W-1:0] n_sat;
	logic signed [BND_W:0] diff;
	logic [BND_W:0] diff_mag;
	logic signed [X_W-1:0] x_sel, hi24;
	logic signed [2*MUL_W-1:0] ps24, ps32;
	logic signed [F_W-1:0] xe, tx, fval;
	logic signed [S_W-1:0] fe, wf;
	logic [S_W-1:0] sm;
	logic [X_W-1:0] hmag;
	logic [71:0] prod;
	logic [D3_W+1:0] d3;

	// one chunk of a divide by three, msb first: {remainder, quotient bits}
	function automatic logic [D3_W+1:0] div3_chunk(logic [1:0] r, logic [D3_W-1:0] d);
		logic [1:0] rr;
		logic [2:0] t;
		logic [D3_W-1:0] q;
		rr = r;
		q = '0;
		for (int k = D3_W - 1; k >= 0; k--) begin
			t = {rr, d[k]};
			q[k] = (t >= 3'd3);
			rr = q[k] ? 2'(t - 3'd3) : t[1:0];
		end
		return {rr, q};
	endfunction

	cqi_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .done(div_done), .quotient(quo));
	cqi_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc = in_valid && in_ready;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign n_sat = (32'(interval_count) > MAX_INTERVALS) ? CNT_W'(MAX_INTERVALS)
		: interval_count;
	assign diff = 17'(upper_bound) - 17'(lower_bound);
	assign diff_mag = diff[BND_W] ? 17'(-diff) : 17'(diff);

	assign hi24 = X_W'(hi_q) <<< 12;
	assign x_sel = (idx_q == n_q) ? hi24 : x_q;
	assign ps24 = mp >>> 24;
	assign ps32 = mp >>> 32;
	assign xe = F_W'(x_cur_q);
	assign tx = ((xe <<< 3) + (xe <<< 1)) >>> 8;
	assign fval = ps32[F_W-1:0] + tx + F_W'(65536);
	assign fe = S_W'(fval);
	assign sm = sum_q[S_W-1] ? S_W'(-sum_q) : S_W'(sum_q);
	assign hmag = h_q[X_W-1] ? X_W'(-h_q) : X_W'(h_q);
	assign prod = 72'(p_lo_q) + (72'(mp) << 21);
	assign d3 = div3_chunk(r3_q, q3_q[DVD_W-1:DVD_W-D3_W]);

	always_comb begin
		if (idx_q == '0 || idx_q == n_q) wf = fe;
		else if (op_q == OP_SIMP && idx_q[0]) wf = fe <<< 2;
		else wf = fe <<< 1;
	end

	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			ST_SQ: begin
				ma = MUL_W'(x_sel);
				mb = MUL_W'(x_sel);
			end
			ST_CB: begin
				ma = ps24[MUL_W-1:0];
				mb = MUL_W'(x_cur_q);
			end
			ST_MP_LO: begin
				ma = $signed(MUL_W'(sm[20:0]));
				mb = $signed(MUL_W'(hmag));
			end
			ST_MP_HI: begin
				ma = $signed(MUL_W'(sm[41:21]));
				mb = $signed(MUL_W'(hmag));
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	always_comb begin
		dreq.start = 1'b0;
		dreq.dividend = '0;
		dreq.divisor = '0;
		if (in_acc && interval_count != '0) begin
			dreq.start = 1'b1;
			dreq.dividend = DVD_W'({diff_mag, 12'b0});
			dreq.divisor = n_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			out_err_q <= 1'b0;
			area_q <= '0;
			err_q <= 1'b0;
			idx_q <= '0;
			n_q <= '0;
			sum_q <= '0;
			h_q <= '0;
			op_q <= 1'b0;
			lo_q <= '0;
			hi_q <= '0;
			neg_h_q <= 1'b0;
			neg_a_q <= 1'b0;
			x_q <= '0;
			x_cur_q <= '0;
			p_lo_q <= '0;
			res_q <= '0;
			q3_q <= '0;
			r3_q <= '0;
			cnt3_q <= '0;
		end else begin
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						op_q <= op;
						lo_q <= lower_bound;
						hi_q <= upper_bound;
						neg_h_q <= diff[BND_W];
						if (interval_count == '0) begin
							err_q <= 1'b1;
							res_q <= '0;
							state_q <= ST_DONE;
						end else begin
							err_q <= 1'b0;
							n_q <= n_sat;
							state_q <= ST_DIV_H;
						end
					end
				end
				ST_DIV_H: begin
					if (div_done) begin
						h_q <= neg_h_q ? X_W'(-$signed({1'b0, quo[X_W-2:0]}))
							: $signed({1'b0, quo[X_W-2:0]});
						x_q <= X_W'(lo_q) <<< 12;
						idx_q <= '0;
						sum_q <= '0;
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					x_cur_q <= x_sel;
					state_q <= ST_CB;
				end
				ST_CB: state_q <= ST_AC;
				ST_AC: begin
					sum_q <= sum_q + wf;
					if (idx_q == n_q) begin
						state_q <= ST_MP_LO;
					end else begin
						idx_q <= idx_q + 1'b1;
						x_q <= x_q + h_q;
						state_q <= ST_SQ;
					end
				end
				ST_MP_LO: begin
					neg_a_q <= sum_q[S_W-1] ^ h_q[X_W-1];
					state_q <= ST_MP_HI;
				end
				ST_MP_HI: begin
					p_lo_q <= mp;
					state_q <= ST_MP_SUM;
				end
				ST_MP_SUM: begin
					r3_q <= '0;
					cnt3_q <= '0;
					if (op_q == OP_SIMP) begin
						q3_q <= prod[71:24];
						state_q <= ST_DIV_A;
					end else begin
						q3_q <= {1'b0, prod[71:25]};
						state_q <= ST_SAT;
					end
				end
				ST_DIV_A: begin
					r3_q <= d3[D3_W+1:D3_W];
					q3_q <= {q3_q[DVD_W-D3_W-1:0], d3[D3_W-1:0]};
					cnt3_q <= cnt3_q + 1'b1;
					if (cnt3_q == 2'd3) state_q <= ST_SAT;
				end
				ST_SAT: begin
					if (neg_a_q) res_q <= (q3_q > NEG_LIM) ? $signed(NEG_LIM[AREA_W-1:0])
						: AREA_W'(-$signed(q3_q));
					else res_q <= (q3_q > POS_LIM) ? $signed(POS_LIM[AREA_W-1:0])
						: $signed(q3_q[AREA_W-1:0]);
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						area_q <= res_q;
						out_err_q <= err_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign area = area_q;
	assign error = out_err_q;
endmodule

@@ rtl/cqi_checker.sv @@
// port-level checker for the cubic quadrature integrator, bound to the top level
`timescale 1ns / 1ps
`include "cubic_quadrature_integrator_defines.svh"
module cqi_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic signed [cqi_pkg::AREA_W-1:0] area,
	input logic error
);
	import cqi_pkg::*;

	`CQI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(area) && $stable(error), "result beat changed while stalled")
	`CQI_ASSERT_NOW(a_err_zero, out_valid && error, area == '0, "error beat with nonzero area")
	`CQI_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready, "ready right after an accepted beat")
endmodule

bind cubic_quadrature_integrator cqi_checker u_cqi_checker (.*);

@@ tb/tb_top.sv @@
// self-checking testbench of the cubic quadrature integrator
`timescale 1ns / 1ps
module tb_top;
	import cqi_pkg::*;

	localparam int MAX_N = DEF_MAX_INTERVALS;
	localparam int STALL_LIMIT = 60000;
	localparam longint AREA_HI = 64'sd549755813887;
	localparam longint AREA_LO = -64'sd549755813888;

	typedef struct {
		logic signed [AREA_W-1:0] area;
		logic error;
	} area_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic op = OP_TRAP;
	logic signed [BND_W-1:0] lower_bound = '0;
	logic signed [BND_W-1:0] upper_bound = '0;
	logic [CNT_W-1:0] interval_count = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [AREA_W-1:0] area;
	logic error;

	area_t expected_areas[$];
	int mismatches = 0;
	int checked = 0;
	int sent = 0;
	int errors_seen = 0;
	int quiet_cycles = 0;
	int burst_left = 0;
	bit hold_off = 1'b0;

	always #6 clk = ~clk;

	cubic_quadrature_integrator DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .lower_bound(lower_bound), .upper_bound(upper_bound),
		.interval_count(interval_count),
		.out_valid(out_valid), .out_ready(out_ready),
		.area(area), .error(error)
	);

	// x in Q.24, f(x) in Q.16
	function automatic longint eval_cubic(longint x);
		longint sq, cu, lin;
		sq = (x * x) >>> 24;
		cu = (sq * x) >>> 32;
		lin = (10 * x) >>> 8;
		return cu + lin + 65536;
	endfunction

	function automatic area_t integrate(logic method, logic signed [BND_W-1:0] lo,
			logic signed [BND_W-1:0] hi, logic [CNT_W-1:0] cnt);
		area_t r;
		longint n, h, lo24, sum, w, a;
		r.area = '0;
		r.error = 1'b0;
		if (cnt == 0) begin
			r.error = 1'b1;
			return r;
		end
		n = (cnt > MAX_N) ? MAX_N : cnt;
		h = ((longint'(hi) - longint'(lo)) * 4096) / n;
		lo24 = longint'(lo) * 4096;
		sum = eval_cubic(lo24) + eval_cubic(longint'(hi) * 4096);
		for (longint i = 1; i < n; i++) begin
			w = (method == OP_SIMP && i[0]) ? 4 : 2;
			sum += w * eval_cubic(lo24 + i * h);
		end
		a = (sum * h) / ((method == OP_SIMP ? 3 : 2) * 64'sd16777216);
		if (a > AREA_HI) a = AREA_HI;
		if (a < AREA_LO) a = AREA_LO;
		r.area = a[AREA_W-1:0];
		return r;
	endfunction

	// receiver stall pattern
	always @(negedge clk) begin
		if (hold_off)
			out_ready <= 1'b0;
		else if (($time / 3000) % 4 == 0)
			out_ready <= 1'b1;
		else
			out_ready <= ($urandom_range(0, 3) != 0);
	end

	// result checker and watchdog
	always @(posedge clk) begin
		area_t exp_r;
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (arst_n && out_valid && out_ready) begin
			checked++;
			if (expected_areas.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat: area=%0d error=%0b", area, error);
			end else begin
				exp_r = expected_areas.pop_front();
				if (error) errors_seen++;
				if (area !== exp_r.area || error !== exp_r.error) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: area exp %0d got %0d, error exp %0b got %0b",
							exp_r.area, area, exp_r.error, error);
				end
			end
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog expired, %0d results outstanding", expected_areas.size());
			$display("cubic_quadrature_integrator test failed");
			$finish;
		end
	end

	task automatic send_request(logic method, logic signed [BND_W-1:0] lo,
			logic signed [BND_W-1:0] hi, logic [CNT_W-1:0] cnt);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 8);
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		op <= method;
		lower_bound <= lo;
		upper_bound <= hi;
		interval_count <= cnt;
		do @(posedge clk); while (!in_ready);
		expected_areas.push_back(integrate(method, lo, hi, cnt));
		sent++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_areas.size() != 0) @(posedge clk);
	endtask

	task automatic test_extremes();
		send_request(OP_TRAP, 16'sh8000, 16'sh7fff, 13'd1);
		send_request(OP_SIMP, 16'sh8000, 16'sh7fff, 13'd2);
		send_request(OP_TRAP, 16'sh7fff, 16'sh8000, 13'd3);
		send_request(OP_SIMP, 16'sh0000, 16'sh0000, 13'd4);
		send_request(OP_TRAP, 16'sh8000, 16'sh8000, 13'd1);
		send_request(OP_SIMP, 16'sh7fff, 16'sh7fff, 13'd1);
		send_request(OP_TRAP, 16'sh8000, 16'sh7fff, 13'd4096);
		send_request(OP_SIMP, 16'sh8000, 16'sh7fff, 13'd8191);
	endtask

	task automatic test_special_cases();
		// zero count, before and after normal requests
		send_request(OP_TRAP, 16'sh1000, 16'sh2000, 13'd0);
		send_request(OP_SIMP, 16'sh7fff, 16'sh8000, 13'd0);
		// odd count with simpson
		send_request(OP_SIMP, 16'sh0000, 16'sh2000, 13'd5);
		send_request(OP_SIMP, 16'shf000, 16'sh3000, 13'd7);
		// reversed bounds
		send_request(OP_TRAP, 16'sh4000, 16'shc000, 13'd6);
		send_request(OP_SIMP, 16'sh2000, 16'she000, 13'd8);
		// count just above the limit
		send_request(OP_TRAP, 16'shf800, 16'sh0800, 13'd4097);
		send_request(OP_TRAP, 16'sh0100, 16'sh0200, 13'd0);
		send_request(OP_SIMP, 16'sh0001, 16'sh0002, 13'd2);
		wait_drained();
	endtask

	task automatic test_random(int count);
		int sel;
		logic [CNT_W-1:0] cnt;
		repeat (count) begin
			sel = $urandom_range(0, 99);
			if (sel < 8) cnt = '0;
			else if (sel < 12) cnt = CNT_W'($urandom_range(100, 600));
			else cnt = CNT_W'($urandom_range(1, 48));
			send_request(1'($urandom_range(0, 1)), BND_W'($urandom), BND_W'($urandom), cnt);
		end
	endtask

	task automatic test_backpressure();
		fork
			begin
				hold_off = 1'b1;
				repeat (400) @(posedge clk);
				hold_off = 1'b0;
			end
			repeat (6)
				send_request(1'($urandom_range(0, 1)), BND_W'($urandom), BND_W'($urandom),
					CNT_W'($urandom_range(0, 12)));
		join
		wait_drained();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_extremes();
		test_special_cases();
		test_backpressure();
		test_random(117);
		wait_drained();
		repeat (200) @(posedge clk);
		$display("%0d requests sent, %0d results checked (%0d with zero count)",
			sent, checked, errors_seen);
		$display("both rules, full-range bounds, saturated counts and long output stall covered");
		if (mismatches == 0 && expected_areas.size() == 0)
			$display("cubic_quadrature_integrator test passed");
		else
			$display("cubic_quadrature_integrator test failed");
		$finish;
	end
endmodule
